[hdl/mrsc_pkg.sv]
// Shared types, codes and constants for the run-length sprite span clipper.
package mrsc_pkg;

   // Stream code fields.
   localparam logic [6:0] RUN_MASK     = 7'd127;
   localparam logic [6:0] END_CODE     = 7'd0;
   localparam logic [6:0] NEWLINE_CODE = 7'd0;

   // Configuration port geometry.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Width of the clip arithmetic: wide enough that edges never wrap.
   localparam int CLIP_WIDTH = 18;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_X     = 3'd0,
      CSR_START_Y     = 3'd1,
      CSR_FILL_COLOR  = 3'd2,
      CSR_CLIP_ENABLE = 3'd3,
      CSR_CLIP_LEFT   = 3'd4,
      CSR_CLIP_TOP    = 3'd5,
      CSR_CLIP_WIDTH  = 3'd6,
      CSR_CLIP_HEIGHT = 3'd7
   } csr_index_type;

   // Configuration as seen by the datapath, with derived clip edges.
   typedef struct packed {
      logic signed [15:0]           start_x;
      logic signed [15:0]           start_y;
      logic [7:0]                   fill_color;
      logic                         clip_enable;
      logic signed [CLIP_WIDTH-1:0] clip_left;
      logic signed [CLIP_WIDTH-1:0] clip_top;
      logic signed [CLIP_WIDTH-1:0] clip_right;
      logic signed [CLIP_WIDTH-1:0] clip_bottom;
   } cfg_type;

   // Drawing cursor carried from one request to the next.
   typedef struct packed {
      logic signed [15:0] column;
      logic signed [15:0] row;
      logic               finished;
   } cursor_type;

   // One decoded fill span.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] row;
      logic signed [15:0] column;
      logic [6:0]         length;
      logic               done;
   } span_type;

endpackage

[hdl/mrsc_req_if.sv]
// Request channel carrying one stream code byte.
interface mrsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       restart;

   modport source (output valid, output code_byte, output restart, input ready);
   modport sink (input valid, input code_byte, input restart, output ready);
endinterface

[hdl/mrsc_rsp_if.sv]
// Result channel carrying one fill span.
interface mrsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] span_row;
   logic signed [15:0] span_column;
   logic [6:0]         span_length;
   logic [7:0]         span_color;
   logic               sprite_done;

   modport source (output valid, output span_row, output span_column, output span_length,
                   output span_color, output sprite_done, input ready);
   modport sink (input valid, input span_row, input span_column, input span_length,
                 input span_color, input sprite_done, output ready);
endinterface

[hdl/mono_rle_span_clipper.sv]
// Top level of the run-length sprite span clipper: request stage, cursor and result register.
//
//   channel  direction  handshake        contents
//   req_bus  in         valid / ready    code_byte, restart
//   rsp_bus  out        valid / ready    span_row, span_column, span_length,
//                                        span_color, sprite_done
//   csr_*    in         write enable     register index, write data
//
// A request that gives a result passes through the request register, where it
// is decoded against the cursor, and then the result register. One request is
// accepted per cycle while the result does not stall; the cursor update is one add.
// Reset is synchronous and clears the cursor, the finished flag and both
// valid flags. A stalled result holds the request stage, which then holds
// the request channel, whether or not the waiting request gives a result.
module mono_rle_span_clipper (
   input  logic                                 clock,
   input  logic                                 reset,
   mrsc_req_if.sink                             req_bus,
   mrsc_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [mrsc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mrsc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   mrsc_pkg::cfg_type    cfg;
   mrsc_pkg::cursor_type cursor_ff;
   mrsc_pkg::cursor_type cursor_in;
   mrsc_pkg::span_type   span;

   logic               req_valid_ff;
   logic [7:0]         req_code_ff;
   logic               req_restart_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [15:0] rsp_row_ff;
   logic signed [15:0] rsp_column_ff;
   logic [6:0]         rsp_length_ff;
   logic [7:0]         rsp_color_ff;
   logic               rsp_done_ff;
   logic               advance;

   mrsc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mrsc_span_calc u_span_calc (
      .code_byte   (req_code_ff),
      .restart     (req_restart_ff),
      .cursor      (cursor_ff),
      .cfg         (cfg),
      .cursor_next (cursor_in),
      .span        (span)
   );

   // The request stage moves on when the result register can take its output.
   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         req_code_ff    <= req_bus.code_byte;
         req_restart_ff <= req_bus.restart;
      end
   end

   // Cursor state advances once per decoded request.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else if (advance) begin
         cursor_ff <= cursor_in;
      end
   end

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && span.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance && span.valid) begin
         rsp_row_ff    <= span.row;
         rsp_column_ff <= span.column;
         rsp_length_ff <= span.length;
         rsp_color_ff  <= cfg.fill_color;
         rsp_done_ff   <= span.done;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.span_row    = rsp_row_ff;
   assign rsp_bus.span_column = rsp_column_ff;
   assign rsp_bus.span_length = rsp_length_ff;
   assign rsp_bus.span_color  = rsp_color_ff;
   assign rsp_bus.sprite_done = rsp_done_ff;

endmodule

[hdl/mrsc_csr.sv]
// Configuration registers with precomputed right and bottom clip edges.
module mrsc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mrsc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mrsc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output mrsc_pkg::cfg_type                    cfg
);

   logic signed [15:0] start_x_ff;
   logic signed [15:0] start_y_ff;
   logic [7:0]         fill_color_ff;
   logic               clip_enable_ff;
   logic signed [15:0] clip_left_ff;
   logic signed [15:0] clip_top_ff;
   logic [14:0]        clip_width_ff;
   logic [14:0]        clip_height_ff;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_right_ff;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_bottom_ff;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_left_ext;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_top_ext;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_right_in;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_bottom_in;

   // Register writes, one index per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         fill_color_ff  <= '0;
         clip_enable_ff <= 1'b0;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= '0;
         clip_height_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            mrsc_pkg::CSR_START_X:     start_x_ff     <= csr_write_data;
            mrsc_pkg::CSR_START_Y:     start_y_ff     <= csr_write_data;
            mrsc_pkg::CSR_FILL_COLOR:  fill_color_ff  <= csr_write_data[7:0];
            mrsc_pkg::CSR_CLIP_ENABLE: clip_enable_ff <= csr_write_data[0];
            mrsc_pkg::CSR_CLIP_LEFT:   clip_left_ff   <= csr_write_data;
            mrsc_pkg::CSR_CLIP_TOP:    clip_top_ff    <= csr_write_data;
            mrsc_pkg::CSR_CLIP_WIDTH:  clip_width_ff  <= csr_write_data[14:0];
            mrsc_pkg::CSR_CLIP_HEIGHT: clip_height_ff <= csr_write_data[14:0];
            default: ;
         endcase
      end
   end

   // The inclusive right and bottom edges are formed at full precision.
   assign clip_left_ext  = {{2{clip_left_ff[15]}}, clip_left_ff};
   assign clip_top_ext   = {{2{clip_top_ff[15]}}, clip_top_ff};
   assign clip_right_in  = clip_left_ext + $signed({3'b000, clip_width_ff})
                           - 18'sd1;
   assign clip_bottom_in = clip_top_ext + $signed({3'b000, clip_height_ff})
                           - 18'sd1;

   // The edges sit in a register of their own behind the clip registers; nothing holds requests off after a write.
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_right_ff  <= -18'sd1;
         clip_bottom_ff <= -18'sd1;
      end else begin
         clip_right_ff  <= clip_right_in;
         clip_bottom_ff <= clip_bottom_in;
      end
   end

   assign cfg.start_x     = start_x_ff;
   assign cfg.start_y     = start_y_ff;
   assign cfg.fill_color  = fill_color_ff;
   assign cfg.clip_enable = clip_enable_ff;
   assign cfg.clip_left   = clip_left_ext;
   assign cfg.clip_top    = clip_top_ext;
   assign cfg.clip_right  = clip_right_ff;
   assign cfg.clip_bottom = clip_bottom_ff;

endmodule

[hdl/mrsc_span_calc.sv]
// Decodes one code byte against the cursor and clips the resulting span.
module mrsc_span_calc (
   input  logic [7:0]           code_byte,
   input  logic                 restart,
   input  mrsc_pkg::cursor_type cursor,
   input  mrsc_pkg::cfg_type    cfg,
   output mrsc_pkg::cursor_type cursor_next,
   output mrsc_pkg::span_type   span
);

   mrsc_pkg::cursor_type base;
   logic [6:0]           low_bits;
   logic [6:0]           run;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] x;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] y;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] x_last;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_start;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_end;
   logic signed [mrsc_pkg::CLIP_WIDTH-1:0] clip_len;
   logic                 overlap;

   // A restart reloads the cursor before the byte is decoded.
   always_comb begin
      base = cursor;
      if (restart) begin
         base.column   = cfg.start_x;
         base.row      = cfg.start_y;
         base.finished = 1'b0;
      end
   end

   assign low_bits = code_byte[6:0] & mrsc_pkg::RUN_MASK;
   assign run      = code_byte[6:0];

   // Clip window test and trimmed span bounds.
   assign x      = {{2{base.column[15]}}, base.column};
   assign y      = {{2{base.row[15]}}, base.row};
   assign x_last = x + $signed({11'd0, run}) - 18'sd1;
   assign overlap = (y >= cfg.clip_top) && (y <= cfg.clip_bottom)
                    && (x_last >= cfg.clip_left) && (x <= cfg.clip_right);
   assign clip_start = (x > cfg.clip_left) ? x : cfg.clip_left;
   assign clip_end   = (x_last < cfg.clip_right) ? x_last : cfg.clip_right;
   assign clip_len   = clip_end - clip_start + 18'sd1;

   // Code classification, cursor update and span selection.
   always_comb begin
      cursor_next = base;
      span.valid  = 1'b0;
      span.row    = base.row;
      span.column = base.column;
      span.length = '0;
      span.done   = 1'b0;
      if (!base.finished) begin
         if (code_byte[7]) begin
            if (low_bits == mrsc_pkg::END_CODE) begin
               cursor_next.finished = 1'b1;
               span.valid           = 1'b1;
               span.done            = 1'b1;
            end else begin
               cursor_next.column = base.column + $signed({9'd0, low_bits});
            end
         end else if (code_byte == {1'b0, mrsc_pkg::NEWLINE_CODE}) begin
            cursor_next.column = cfg.start_x;
            cursor_next.row    = base.row + 16'sd1;
         end else begin
            cursor_next.column = base.column + $signed({9'd0, run});
            if (run != 7'd0) begin
               if (!cfg.clip_enable) begin
                  span.valid  = 1'b1;
                  span.length = run;
               end else if (overlap && (clip_len > 18'sd0)) begin
                  span.valid  = 1'b1;
                  span.column = clip_start[15:0];
                  span.length = clip_len[6:0];
               end
            end
         end
      end
   end

endmodule
